// ===== rtl/i2c_master_transfer_sequencer_core_assert.svh =====
// Assertion macros shared by the checker of the I2C transfer sequencer.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_CORE_ASSERT_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define I2CMTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define I2CMTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/i2cmts_pkg.sv =====
// Types and codes of the I2C master transfer sequencer.
`default_nettype none
package i2cmts_pkg;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_LENGTH  = 1'd1;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_EVENT = 1'b1;

  typedef enum logic [3:0] {
    EV_START       = 4'd0,
    EV_RSTART      = 4'd1,
    EV_ADDRW_ACK   = 4'd2,
    EV_ADDRW_NACK  = 4'd3,
    EV_DATAW_ACK   = 4'd4,
    EV_DATAW_NACK  = 4'd5,
    EV_ARB_LOST    = 4'd6,
    EV_ADDRR_ACK   = 4'd7,
    EV_ADDRR_NACK  = 4'd8,
    EV_DATAR_ACK   = 4'd9,
    EV_DATAR_NACK  = 4'd10,
    EV_OTHER       = 4'd11
  } bus_ev_t;

  // Result word without the transmit byte, which comes from the store.
  typedef struct packed {
    logic       tx_valid;
    logic       start_request;
    logic       start_clear;
    logic       stop_request;
    logic       ack_update;
    logic       ack_level;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [4:0] rx_position;
    logic       busy_res;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/i2cmts_store.sv =====
// Transmit byte store: one write port, one registered read port.
`default_nettype none
module i2cmts_store #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold the read word until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/i2cmts_seq.sv =====
// Event decoder with position counters, configuration and store access.
`default_nettype none
module i2cmts_seq #(
  parameter int unsigned BUFFER_DEPTH = 32,
  parameter int unsigned AW           = 5
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                take,
  input  wire logic                                req_type,
  input  wire logic [4:0]                          load_index,
  input  wire logic [7:0]                          load_byte,
  input  wire logic [3:0]                          bus_event,
  input  wire logic [7:0]                          rx_data,
  input  wire logic                                cfg_wr_en,
  input  wire logic [i2cmts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [i2cmts_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic                                     wr_en,
  output logic      [AW-1:0]                       wr_addr,
  output logic      [7:0]                          wr_data,
  output logic                                     rd_en,
  output logic      [AW-1:0]                       rd_addr,
  output i2cmts_pkg::res_t                         res
);

  logic [5:0] send_pos_r, send_pos_nxt;
  logic [5:0] recv_pos_r, recv_pos_nxt;
  logic       active_r, active_nxt;
  logic [4:0] write_len_r;
  logic [5:0] read_len_r;

  logic [5:0] send_sel;
  logic [5:0] recv_inc;
  logic       emit;
  i2cmts_pkg::bus_ev_t ev;

  // Position modulo the store depth, one entry per 6-bit position.
  logic [AW-1:0] mod_tbl [64];

  for (genvar g = 0; g < 64; g++) begin : g_mod
    assign mod_tbl[g] = AW'(g % BUFFER_DEPTH);
  end

  assign ev       = i2cmts_pkg::bus_ev_t'(bus_event);
  assign recv_inc = recv_pos_r + 6'd1;
  assign send_sel = (ev == i2cmts_pkg::EV_START) ? 6'd0 : send_pos_r;

  always_comb begin
    emit         = 1'b0;
    send_pos_nxt = send_pos_r;
    recv_pos_nxt = recv_pos_r;
    active_nxt   = active_r;
    res          = '0;
    if (req_type == i2cmts_pkg::REQ_EVENT) begin
      unique case (ev)
        i2cmts_pkg::EV_START, i2cmts_pkg::EV_RSTART: begin
          if (ev == i2cmts_pkg::EV_RSTART) begin
            recv_pos_nxt = 6'd0;
          end
          emit              = 1'b1;
          res.start_clear   = 1'b1;
          active_nxt        = 1'b1;
        end
        i2cmts_pkg::EV_ADDRW_ACK: begin
          if (write_len_r <= 5'd1) begin
            res.stop_request = 1'b1;
            active_nxt       = 1'b0;
          end else begin
            emit = 1'b1;
          end
        end
        i2cmts_pkg::EV_DATAW_ACK: begin
          if (send_pos_r < {1'b0, write_len_r}) begin
            emit = 1'b1;
          end else if (read_len_r != 6'd0) begin
            res.start_request = 1'b1;
          end else begin
            res.stop_request = 1'b1;
            active_nxt       = 1'b0;
          end
        end
        i2cmts_pkg::EV_ADDRR_ACK: begin
          res.ack_update = 1'b1;
          res.ack_level  = (read_len_r > 6'd1);
        end
        i2cmts_pkg::EV_DATAR_ACK, i2cmts_pkg::EV_DATAR_NACK: begin
          res.rx_valid    = 1'b1;
          res.rx_byte     = rx_data;
          res.rx_position = recv_pos_r[4:0];
          recv_pos_nxt    = recv_inc;
          if (ev == i2cmts_pkg::EV_DATAR_ACK) begin
            // NACK the last requested byte.
            res.ack_update = 1'b1;
            res.ack_level  = (({1'b0, recv_inc} + 7'd1) < {1'b0, read_len_r});
          end else begin
            res.stop_request = 1'b1;
            active_nxt       = 1'b0;
          end
        end
        default: begin
          res.stop_request = 1'b1;
          active_nxt       = 1'b0;
        end
      endcase
      if (emit) begin
        res.tx_valid = 1'b1;
        send_pos_nxt = send_sel + 6'd1;
      end
    end
    res.busy_res = active_nxt;
  end

  assign wr_en   = take && (req_type == i2cmts_pkg::REQ_LOAD);
  assign wr_addr = mod_tbl[{1'b0, load_index}];
  assign wr_data = load_byte;
  assign rd_en   = take && emit;
  assign rd_addr = mod_tbl[send_sel];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_pos_r <= 6'd0;
      recv_pos_r <= 6'd0;
      active_r   <= 1'b0;
    end else if (take) begin
      send_pos_r <= send_pos_nxt;
      recv_pos_r <= recv_pos_nxt;
      active_r   <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_len_r <= 5'd1;
      read_len_r  <= 6'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        i2cmts_pkg::CFG_WRITE_LENGTH: write_len_r <= cfg_wdata[4:0];
        i2cmts_pkg::CFG_READ_LENGTH:  read_len_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/i2cmts_outq.sv =====
// Read-data stage and output register of the result word.
`default_nettype none
module i2cmts_outq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              take,
  input  i2cmts_pkg::res_t       res_in,
  input  wire logic [7:0]        rd_data,
  input  wire logic              out_stall,
  output logic                   hold,
  output logic                   out_valid,
  output i2cmts_pkg::res_t       out_res,
  output logic      [7:0]        out_tx_byte
);

  logic             s1_valid_r;
  i2cmts_pkg::res_t s1_res_r;
  logic             out_valid_r;
  i2cmts_pkg::res_t out_res_r;
  logic [7:0]       out_tx_byte_r;
  logic             out_free;
  logic             s1_move;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_free;
  // Store read data stays put while the stage holds a word that cannot move on.
  assign hold     = s1_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_res_r <= res_in;
    end
    if (s1_move) begin
      out_res_r     <= s1_res_r;
      out_tx_byte_r <= s1_res_r.tx_valid ? rd_data : 8'd0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_res     = out_res_r;
  assign out_tx_byte = out_tx_byte_r;

endmodule
`default_nettype wire

// ===== rtl/i2c_master_transfer_sequencer_core.sv =====
// I2C master transfer sequencer: takes store loads and bus status events and
// answers each accepted word with one action word (byte to send, start/stop
// requests, acknowledge level, received byte). One word is accepted per clock
// while in_stall is low; its result is registered in the read stage, with the
// synchronous read of the transmit store, and then in the output register.
// in_stall rises only when both hold words and out_stall is high.
`default_nettype none
module i2c_master_transfer_sequencer_core #(
  parameter int unsigned BUFFER_DEPTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_req_type,
  input  wire logic [4:0]                        in_load_index,
  input  wire logic [7:0]                        in_load_byte,
  input  wire logic [3:0]                        in_bus_event,
  input  wire logic [7:0]                        in_rx_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_tx_valid,
  output logic      [7:0]                        out_tx_byte,
  output logic                                   out_start_request,
  output logic                                   out_start_clear,
  output logic                                   out_stop_request,
  output logic                                   out_ack_update,
  output logic                                   out_ack_level,
  output logic                                   out_rx_valid,
  output logic      [7:0]                        out_rx_byte,
  output logic      [4:0]                        out_rx_position,
  output logic                                   out_busy_res,
  input  wire logic                              cfg_wr_en,
  input  wire logic [i2cmts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [i2cmts_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  logic             take;
  logic             hold;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [7:0]       wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [7:0]       rd_data;
  i2cmts_pkg::res_t res;
  i2cmts_pkg::res_t out_res;

  assign in_stall = hold;
  assign take     = in_valid && !hold;

  i2cmts_seq #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .AW          (AW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .req_type  (in_req_type),
    .load_index(in_load_index),
    .load_byte (in_load_byte),
    .bus_event (in_bus_event),
    .rx_data   (in_rx_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .res       (res)
  );

  i2cmts_store #(
    .DEPTH(BUFFER_DEPTH),
    .AW   (AW)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  i2cmts_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .res_in     (res),
    .rd_data    (rd_data),
    .out_stall  (out_stall),
    .hold       (hold),
    .out_valid  (out_valid),
    .out_res    (out_res),
    .out_tx_byte(out_tx_byte)
  );

  assign out_tx_valid      = out_res.tx_valid;
  assign out_start_request = out_res.start_request;
  assign out_start_clear   = out_res.start_clear;
  assign out_stop_request  = out_res.stop_request;
  assign out_ack_update    = out_res.ack_update;
  assign out_ack_level     = out_res.ack_level;
  assign out_rx_valid      = out_res.rx_valid;
  assign out_rx_byte       = out_res.rx_byte;
  assign out_rx_position   = out_res.rx_position;
  assign out_busy_res      = out_res.busy_res;

endmodule
`default_nettype wire

// ===== rtl/i2cmts_checker.sv =====
// Port-level checks of the I2C transfer sequencer and their binding.
`default_nettype none
`include "i2c_master_transfer_sequencer_core_assert.svh"
module i2cmts_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_tx_valid,
  input wire logic [7:0] out_tx_byte,
  input wire logic       out_stop_request,
  input wire logic       out_ack_update,
  input wire logic       out_ack_level,
  input wire logic       out_rx_valid,
  input wire logic [7:0] out_rx_byte,
  input wire logic [4:0] out_rx_position,
  input wire logic       out_busy_res
);

  `I2CMTS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_tx_byte) && $stable(out_rx_byte), "stalled word changed")
  `I2CMTS_ASSERT_NOW(a_tx_zero, out_valid && !out_tx_valid, out_tx_byte == 8'd0, "tx byte without tx valid")
  `I2CMTS_ASSERT_NOW(a_rx_zero, out_valid && !out_rx_valid, out_rx_byte == 8'd0 && out_rx_position == 5'd0, "rx fields without rx valid")
  `I2CMTS_ASSERT_NOW(a_stop_idle, out_valid && out_stop_request, !out_busy_res && !out_tx_valid && !(out_ack_update && out_ack_level), "stop left transfer active")

endmodule

bind i2c_master_transfer_sequencer_core i2cmts_checker u_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_tx_valid    (out_tx_valid),
  .out_tx_byte     (out_tx_byte),
  .out_stop_request(out_stop_request),
  .out_ack_update  (out_ack_update),
  .out_ack_level   (out_ack_level),
  .out_rx_valid    (out_rx_valid),
  .out_rx_byte     (out_rx_byte),
  .out_rx_position (out_rx_position),
  .out_busy_res    (out_busy_res)
);
`default_nettype wire
